### rtl/mlbc_pkg.sv
// ----------------------------------------------------------------------------
// mlbc_pkg
// Shared types and constants for the multi-LED blink controller.
// ----------------------------------------------------------------------------
package mlbc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned LedCountDefault      = 5;
  localparam int unsigned DefaultPeriodDefault = 1000;

  // Fixed field widths of the channels
  localparam int unsigned KindW   = 4;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned OutLeds = 5;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 3;

  localparam logic [PeriodW-1:0] CountMax = '1;

  typedef enum logic [KindW-1:0] {
    KIND_TICK       = 4'd0,
    KIND_SET        = 4'd1,
    KIND_TOGGLE     = 4'd2,
    KIND_BLINK      = 4'd3,
    KIND_STOP_KEEP  = 4'd4,
    KIND_STOP_VALUE = 4'd5,
    KIND_BATTERY    = 4'd6,
    KIND_SET_ALL    = 4'd7,
    KIND_CLEAR      = 4'd8,
    KIND_ALL_ON     = 4'd9,
    KIND_PATTERN    = 4'd10,
    KIND_PERIOD     = 4'd11,
    KIND_CONFIG     = 4'd12
  } kind_t;

  typedef enum logic [LevelW-1:0] {
    LEVEL_LOW  = 2'd0,
    LEVEL_MED  = 2'd1,
    LEVEL_HIGH = 2'd2,
    LEVEL_NONE = 2'd3
  } level_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BATT_LOW  = 2'd0,
    CFG_BATT_MED  = 2'd1,
    CFG_BATT_HIGH = 2'd2
  } cfg_idx_t;

  localparam logic [PosW-1:0] BattLowReset  = 3'd1;
  localparam logic [PosW-1:0] BattMedReset  = 3'd2;
  localparam logic [PosW-1:0] BattHighReset = 3'd3;

endpackage

### rtl/multi_led_blink_controller.sv
// ----------------------------------------------------------------------------
// multi_led_blink_controller
// Per-LED blink timers, single-LED commands, battery bar and pattern control.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                         | Direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid/in_ready, kind, led_index, value, mask, | sink
//          | period_ms, level                                |
//  out     | out_valid/out_ready, led_outputs, blinking_leds, | source
//          | config_mode_on, port_written                    |
//  cfg     | cfg_we, cfg_index, cfg_data                     | sink
//
// One beat per cycle in steady state while the result is not stalled. An item
// waits in the input register while the lane update logic runs, then lands
// in the result register, from which it can be taken. All LED lanes update
// in parallel.
// Synchronous reset clears the LED, blink and config bits, counters and
// phases, and loads the default period. A stalled result holds the pipeline;
// the input side keeps taking beats while its register is free.

module multi_led_blink_controller #(
  parameter int unsigned LED_COUNT         = mlbc_pkg::LedCountDefault,
  parameter int unsigned DEFAULT_PERIOD_MS = mlbc_pkg::DefaultPeriodDefault
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mlbc_pkg::KindW-1:0]   kind,
  input  logic [mlbc_pkg::IndexW-1:0]  led_index,
  input  logic                         value,
  input  logic [mlbc_pkg::MaskW-1:0]   mask,
  input  logic [mlbc_pkg::PeriodW-1:0] period_ms,
  input  logic [mlbc_pkg::LevelW-1:0]  level,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mlbc_pkg::OutLeds-1:0] led_outputs,
  output logic [mlbc_pkg::OutLeds-1:0] blinking_leds,
  output logic                         config_mode_on,
  output logic                         port_written,

  input  logic                         cfg_we,
  input  logic [mlbc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mlbc_pkg::CfgW-1:0]    cfg_data
);

  localparam int unsigned PW = mlbc_pkg::PeriodW;

  // Configuration registers
  logic [mlbc_pkg::PosW-1:0] batt_low_pos;
  logic [mlbc_pkg::PosW-1:0] batt_med_pos;
  logic [mlbc_pkg::PosW-1:0] batt_high_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      batt_low_pos  <= mlbc_pkg::BattLowReset;
      batt_med_pos  <= mlbc_pkg::BattMedReset;
      batt_high_pos <= mlbc_pkg::BattHighReset;
    end else if (cfg_we) begin
      case (mlbc_pkg::cfg_idx_t'(cfg_index))
        mlbc_pkg::CFG_BATT_LOW:  batt_low_pos  <= cfg_data;
        mlbc_pkg::CFG_BATT_MED:  batt_med_pos  <= cfg_data;
        mlbc_pkg::CFG_BATT_HIGH: batt_high_pos <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                          s1_valid;
  mlbc_pkg::kind_t               kind_q;
  logic [mlbc_pkg::IndexW-1:0]   index_q;
  logic                          value_q;
  logic [mlbc_pkg::MaskW-1:0]    mask_q;
  logic [PW-1:0]                 period_q;
  mlbc_pkg::level_t              level_q;
  logic                          s2_free;
  logic                          s1_fire;

  assign s2_free  = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q   <= mlbc_pkg::kind_t'(kind);
      index_q  <= led_index;
      value_q  <= value;
      mask_q   <= mask;
      period_q <= period_ms;
      level_q  <= mlbc_pkg::level_t'(level);
    end
  end

  // LED state
  logic [LED_COUNT-1:0] led_bits, led_bits_next;
  logic [LED_COUNT-1:0] blink_bits, blink_bits_next;
  logic                 config_flag, config_flag_next;
  logic [PW-1:0]        blink_period [LED_COUNT];
  logic [PW-1:0]        blink_period_next [LED_COUNT];
  logic [PW-1:0]        since_toggle [LED_COUNT];
  logic [PW-1:0]        since_toggle_next [LED_COUNT];
  logic [LED_COUNT-1:0] blink_phase, blink_phase_next;
  logic                 wrote;

  // Per-lane decode of the addressed LED, the pattern mask and the battery bar
  logic [LED_COUNT-1:0] sel, pat, seg_lo, seg_me, seg_hi, seg_all, seg_on;

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      sel[i]    = (index_q == mlbc_pkg::IndexW'(i));
      pat[i]    = mask_q[i];
      seg_lo[i] = (batt_low_pos == mlbc_pkg::PosW'(i));
      seg_me[i] = (batt_med_pos == mlbc_pkg::PosW'(i));
      seg_hi[i] = (batt_high_pos == mlbc_pkg::PosW'(i));
    end
    seg_all = seg_lo | seg_me | seg_hi;
    case (level_q)
      mlbc_pkg::LEVEL_LOW:  seg_on = seg_lo;
      mlbc_pkg::LEVEL_MED:  seg_on = seg_lo | seg_me;
      mlbc_pkg::LEVEL_HIGH: seg_on = seg_all;
      default:              seg_on = '0;
    endcase
  end

  logic idx_ok;
  assign idx_ok = |sel;

  always_comb begin
    logic [PW-1:0]        cnt;
    logic [LED_COUNT-1:0] arm;
    led_bits_next    = led_bits;
    blink_bits_next  = blink_bits;
    config_flag_next = config_flag;
    blink_phase_next = blink_phase;
    wrote            = 1'b0;
    arm              = '0;
    cnt              = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      blink_period_next[i] = blink_period[i];
      since_toggle_next[i] = since_toggle[i];
    end

    case (kind_q)
      mlbc_pkg::KIND_TICK: begin
        for (int i = 0; i < LED_COUNT; i++) begin
          if (blink_bits[i]) begin
            cnt = (since_toggle[i] == mlbc_pkg::CountMax) ? since_toggle[i]
                                                          : since_toggle[i] + 1'b1;
            if (cnt >= (blink_period[i] >> 1)) begin
              blink_phase_next[i]  = !blink_phase[i];
              led_bits_next[i]     = !blink_phase[i];
              since_toggle_next[i] = '0;
              wrote                = 1'b1;
            end else begin
              since_toggle_next[i] = cnt;
            end
          end
        end
      end
      mlbc_pkg::KIND_SET, mlbc_pkg::KIND_STOP_VALUE: begin
        blink_bits_next = blink_bits & ~sel;
        led_bits_next   = value_q ? (led_bits | sel) : (led_bits & ~sel);
        wrote           = idx_ok;
      end
      mlbc_pkg::KIND_TOGGLE: begin
        blink_bits_next = blink_bits & ~sel;
        led_bits_next   = led_bits ^ sel;
        wrote           = idx_ok;
      end
      mlbc_pkg::KIND_BLINK: begin
        arm   = sel;
        wrote = idx_ok;
      end
      mlbc_pkg::KIND_STOP_KEEP: begin
        blink_bits_next = blink_bits & ~sel;
      end
      mlbc_pkg::KIND_BATTERY: begin
        blink_bits_next = blink_bits & ~seg_all;
        led_bits_next   = (led_bits & ~seg_all) | seg_on;
        wrote           = 1'b1;
      end
      mlbc_pkg::KIND_SET_ALL: begin
        blink_bits_next = '0;
        led_bits_next   = pat;
        wrote           = 1'b1;
      end
      mlbc_pkg::KIND_CLEAR: begin
        blink_bits_next  = '0;
        config_flag_next = 1'b0;
        led_bits_next    = '0;
        wrote            = 1'b1;
      end
      mlbc_pkg::KIND_ALL_ON: begin
        blink_bits_next = '0;
        led_bits_next   = '1;
        wrote           = 1'b1;
      end
      mlbc_pkg::KIND_PATTERN: begin
        arm   = pat;
        wrote = 1'b1;
      end
      mlbc_pkg::KIND_PERIOD: begin
        for (int i = 0; i < LED_COUNT; i++) begin
          if (sel[i]) begin
            blink_period_next[i] = period_q;
          end
        end
      end
      mlbc_pkg::KIND_CONFIG: begin
        if (value_q) begin
          config_flag_next = 1'b1;
          arm              = '1;
        end else begin
          blink_bits_next  = '0;
          config_flag_next = 1'b0;
          led_bits_next    = '0;
        end
        wrote = 1'b1;
      end
      default: ;
    endcase

    // Start blinking on armed lanes: phase and output go high, count restarts
    for (int i = 0; i < LED_COUNT; i++) begin
      if (arm[i]) begin
        blink_period_next[i] = period_q;
        since_toggle_next[i] = '0;
        blink_phase_next[i]  = 1'b1;
        led_bits_next[i]     = 1'b1;
        blink_bits_next[i]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_bits    <= '0;
      blink_bits  <= '0;
      config_flag <= 1'b0;
      blink_phase <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        blink_period[i] <= PW'(DEFAULT_PERIOD_MS);
        since_toggle[i] <= '0;
      end
    end else if (s1_fire) begin
      led_bits    <= led_bits_next;
      blink_bits  <= blink_bits_next;
      config_flag <= config_flag_next;
      blink_phase <= blink_phase_next;
      for (int i = 0; i < LED_COUNT; i++) begin
        blink_period[i] <= blink_period_next[i];
        since_toggle[i] <= since_toggle_next[i];
      end
    end
  end

  // Fit the lane vectors to the fixed result width
  logic [mlbc_pkg::OutLeds-1:0] led_w, blink_w;

  for (genvar g = 0; g < mlbc_pkg::OutLeds; g++) begin : g_out
    if (g < LED_COUNT) begin : g_lane
      assign led_w[g]   = led_bits_next[g];
      assign blink_w[g] = blink_bits_next[g];
    end else begin : g_none
      assign led_w[g]   = 1'b0;
      assign blink_w[g] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      led_outputs    <= led_w;
      blinking_leds  <= blink_w;
      config_mode_on <= config_flag_next;
      port_written   <= wrote;
    end
  end

endmodule
